[rtl/core/pme_pkg.sv]
// pme_pkg: shared types, constants and fixed-point helpers for the pid itae evaluator
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package pme_pkg;

  localparam int unsigned SIM_STEPS_DEF  = 200;
  localparam int unsigned SKIP_STEPS_DEF = 20;

  localparam int unsigned STEP_W = 8;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COST_W = 48;
  localparam int unsigned OP_W   = 34;
  localparam int unsigned WIDE_W = 66;
  localparam int unsigned NITAE_W = 27;

  localparam logic [OP_W-1:0] C_DT     = OP_W'(33'd42949673);
  localparam logic [OP_W-1:0] C_KEEP   = OP_W'(33'd4252017623);
  localparam logic [OP_W-1:0] C_DRIVE  = OP_W'(33'd429496730);
  localparam logic [OP_W-1:0] C_ITAE   = OP_W'(33'd429497);
  localparam logic [OP_W-1:0] C_DERIV  = OP_W'(33'd100);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ERR,
    PH_DT,
    PH_INT,
    PH_DER,
    PH_KP,
    PH_KI,
    PH_KD,
    PH_KEEP,
    PH_DRIVE,
    PH_SPEED,
    PH_COST,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic              clear;
    phase_e            phase;
    logic [STEP_W-1:0] step;
    logic              cost_en;
  } ctrl_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    logic [WIDE_W-DATA_W:0] hi;
    hi = x[WIDE_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      r.ovf = 1'b0;
      r.val = x[DATA_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] v;
    v = x + (WIDE_W'(1) <<< 31);
    return v >>> 32;
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] v;
    v = x + (WIDE_W'(1) <<< 15);
    return v >>> 16;
  endfunction

endpackage

[rtl/core/pid_motor_itae_eval.sv]
// pid_motor_itae_eval: top level of the pid step-response itae cost evaluator
// depends on pme_pkg, pme_ctrl and pme_datapath (which holds pme_mul)
//
// usage:
//   a request is taken on the rising edge where start_i is high and busy_o is low;
//   prop_gain_i, integ_gain_i and deriv_gain_i (unsigned q8.16) are sampled then.
//   the setpoint register is written through target_speed_we_i / target_speed_i
//   (signed q16.16); it resets to zero. the user must write it only while the
//   block is idle; the block itself does not enforce this. each request runs
//   SIM_STEPS closed-loop steps, all multiplications going through one
//   registered 34x34 multiplier. the result is shown on itae_cost_o /
//   cost_saturated_o when done_o is high and holds until the next request.
//   busy_o stays high from acceptance through the done_o cycle, so a new
//   request is taken at the earliest in the cycle after done_o.
//   the receiver cannot stall; done_o is a one-cycle strobe.
//   reset is asynchronous and active low; it returns the sequencer to idle,
//   clears the setpoint and drops any request in flight.
`timescale 1ns / 1ps

module pid_motor_itae_eval #(
  parameter int unsigned SIM_STEPS  = pme_pkg::SIM_STEPS_DEF,
  parameter int unsigned SKIP_STEPS = pme_pkg::SKIP_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [pme_pkg::GAIN_W-1:0]         prop_gain_i,
  input  logic [pme_pkg::GAIN_W-1:0]         integ_gain_i,
  input  logic [pme_pkg::GAIN_W-1:0]         deriv_gain_i,
  input  logic                               target_speed_we_i,
  input  logic signed [pme_pkg::DATA_W-1:0]  target_speed_i,
  output logic                               done_o,
  output logic [pme_pkg::COST_W-1:0]         itae_cost_o,
  output logic                               cost_saturated_o
);
  import pme_pkg::*;

  ctrl_t                    ctrl;
  logic signed [DATA_W-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (target_speed_we_i) begin
      target_q <= target_speed_i;
    end
  end

  pme_ctrl #(
    .SIM_STEPS  (SIM_STEPS),
    .SKIP_STEPS (SKIP_STEPS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  pme_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .prop_gain_i      (prop_gain_i),
    .integ_gain_i     (integ_gain_i),
    .deriv_gain_i     (deriv_gain_i),
    .target_speed_i   (target_q),
    .itae_cost_o      (itae_cost_o),
    .cost_saturated_o (cost_saturated_o)
  );

endmodule

[rtl/core/pme_mul.sv]
// pme_mul: shared signed multiplier with a registered product
// depends on pme_pkg for operand and product widths
`timescale 1ns / 1ps

module pme_mul (
  input  logic                               clk_i,
  input  logic signed [pme_pkg::OP_W-1:0]    op_a_i,
  input  logic signed [pme_pkg::OP_W-1:0]    op_b_i,
  output logic signed [pme_pkg::WIDE_W-1:0]  prod_o
);
  import pme_pkg::*;

  logic signed [2*OP_W-1:0]   full;
  logic signed [WIDE_W-1:0]   prod_q;

  assign full   = op_a_i * op_b_i;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= full[WIDE_W-1:0];
  end

endmodule

[rtl/core/pme_datapath.sv]
// pme_datapath: loop state registers, operand selection and write-back around the multiplier
// depends on pme_pkg and pme_mul
`timescale 1ns / 1ps

module pme_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pme_pkg::ctrl_t                     ctrl_i,
  input  logic [pme_pkg::GAIN_W-1:0]         prop_gain_i,
  input  logic [pme_pkg::GAIN_W-1:0]         integ_gain_i,
  input  logic [pme_pkg::GAIN_W-1:0]         deriv_gain_i,
  input  logic signed [pme_pkg::DATA_W-1:0]  target_speed_i,
  output logic [pme_pkg::COST_W-1:0]         itae_cost_o,
  output logic                               cost_saturated_o
);
  import pme_pkg::*;

  logic [GAIN_W-1:0]         kp_q, ki_q, kd_q;
  logic signed [DATA_W-1:0]  err_q, integ_q, deriv_q, prev_q, speed_q, u_q;
  logic signed [DATA_W-1:0]  err_d, integ_d, deriv_d, prev_d, speed_d, u_d;
  logic signed [OP_W-1:0]    keep_q, keep_d;
  logic [NITAE_W-1:0]        nitae_q, nitae_d;
  logic signed [WIDE_W-1:0]  acc_q, acc_d;
  logic [COST_W-1:0]         cost_q, cost_d;
  logic                      ovf_q, ovf_d;

  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [WIDE_W-1:0]  prod;
  logic [DATA_W:0]           err_mag;
  logic [COST_W:0]           cost_sum;
  logic signed [WIDE_W-1:0]  prod_rnd;
  sat_t                      sat_err, sat_int, sat_der, sat_u, sat_spd;

  pme_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign err_mag  = err_q[DATA_W-1] ? (DATA_W+1)'(-(DATA_W+1)'(err_q))
                                    : (DATA_W+1)'(err_q);
  assign prod_rnd = rnd32(prod);
  assign cost_sum = {1'b0, cost_q} + {1'b0, prod_rnd[COST_W-1:0]};

  assign sat_err = sat32(WIDE_W'(target_speed_i) - WIDE_W'(speed_q));
  assign sat_int = sat32(WIDE_W'(integ_q) + prod_rnd);
  assign sat_der = sat32(prod);
  assign sat_u   = sat32(rnd16(acc_q));
  assign sat_spd = sat32(WIDE_W'(keep_q) + prod_rnd);

  // operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl_i.phase)
      PH_ERR: begin
        op_a = OP_W'(ctrl_i.step);
        op_b = C_ITAE;
      end
      PH_DT: begin
        op_a = OP_W'(err_q);
        op_b = C_DT;
      end
      PH_INT: begin
        op_a = OP_W'(err_q) - OP_W'(prev_q);
        op_b = C_DERIV;
      end
      PH_DER: begin
        op_a = OP_W'(err_q);
        op_b = OP_W'(kp_q);
      end
      PH_KP: begin
        op_a = OP_W'(integ_q);
        op_b = OP_W'(ki_q);
      end
      PH_KI: begin
        op_a = OP_W'(deriv_q);
        op_b = OP_W'(kd_q);
      end
      PH_KD: begin
        op_a = OP_W'(speed_q);
        op_b = C_KEEP;
      end
      PH_DRIVE: begin
        op_a = OP_W'(u_q);
        op_b = C_DRIVE;
      end
      PH_SPEED: begin
        op_a = OP_W'(nitae_q);
        op_b = OP_W'(err_mag);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // write-back
  always_comb begin
    err_d   = err_q;
    integ_d = integ_q;
    deriv_d = deriv_q;
    prev_d  = prev_q;
    speed_d = speed_q;
    u_d     = u_q;
    keep_d  = keep_q;
    nitae_d = nitae_q;
    acc_d   = acc_q;
    cost_d  = cost_q;
    ovf_d   = ovf_q;
    if (ctrl_i.clear) begin
      integ_d = '0;
      prev_d  = '0;
      speed_d = '0;
      cost_d  = '0;
      ovf_d   = 1'b0;
    end else begin
      unique case (ctrl_i.phase)
        PH_ERR: begin
          err_d = sat_err.val;
          ovf_d = ovf_q | sat_err.ovf;
        end
        PH_DT: nitae_d = prod[NITAE_W-1:0];
        PH_INT: begin
          integ_d = sat_int.val;
          ovf_d   = ovf_q | sat_int.ovf;
        end
        PH_DER: begin
          deriv_d = sat_der.val;
          ovf_d   = ovf_q | sat_der.ovf;
        end
        PH_KP: acc_d = prod;
        PH_KI, PH_KD: acc_d = acc_q + prod;
        PH_KEEP: begin
          u_d    = sat_u.val;
          ovf_d  = ovf_q | sat_u.ovf;
          keep_d = prod_rnd[OP_W-1:0];
        end
        PH_SPEED: begin
          speed_d = sat_spd.val;
          ovf_d   = ovf_q | sat_spd.ovf;
        end
        PH_COST: begin
          prev_d = err_q;
          if (ctrl_i.cost_en) begin
            if (cost_sum[COST_W]) begin
              cost_d = '1;
              ovf_d  = 1'b1;
            end else begin
              cost_d = cost_sum[COST_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      kp_q <= prop_gain_i;
      ki_q <= integ_gain_i;
      kd_q <= deriv_gain_i;
    end
    err_q   <= err_d;
    integ_q <= integ_d;
    deriv_q <= deriv_d;
    prev_q  <= prev_d;
    speed_q <= speed_d;
    u_q     <= u_d;
    keep_q  <= keep_d;
    nitae_q <= nitae_d;
    acc_q   <= acc_d;
    cost_q  <= cost_d;
  end

  assign itae_cost_o      = ovf_q ? '1 : cost_q;
  assign cost_saturated_o = ovf_q;

endmodule

[rtl/core/pme_ctrl.sv]
// pme_ctrl: sequencer that walks the eleven phases of each simulation step
// depends on pme_pkg for the phase enum and control struct
`timescale 1ns / 1ps

module pme_ctrl #(
  parameter int unsigned SIM_STEPS  = pme_pkg::SIM_STEPS_DEF,
  parameter int unsigned SKIP_STEPS = pme_pkg::SKIP_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  output pme_pkg::ctrl_t ctrl_o
);
  import pme_pkg::*;

  phase_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == STEP_W'(SIM_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PH_IDLE:  if (start_i) state_d = PH_ERR;
      PH_ERR:   state_d = PH_DT;
      PH_DT:    state_d = PH_INT;
      PH_INT:   state_d = PH_DER;
      PH_DER:   state_d = PH_KP;
      PH_KP:    state_d = PH_KI;
      PH_KI:    state_d = PH_KD;
      PH_KD:    state_d = PH_KEEP;
      PH_KEEP:  state_d = PH_DRIVE;
      PH_DRIVE: state_d = PH_SPEED;
      PH_SPEED: state_d = PH_COST;
      PH_COST:  state_d = last_step ? PH_DONE : PH_ERR;
      PH_DONE:  state_d = PH_IDLE;
      default:  state_d = PH_IDLE;
    endcase
  end

  // step counter
  always_comb begin
    step_d = step_q;
    if (state_q == PH_IDLE) begin
      step_d = '0;
    end else if (state_q == PH_COST) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // outputs
  always_comb begin
    busy_o         = (state_q != PH_IDLE);
    done_o         = (state_q == PH_DONE);
    ctrl_o.clear   = (state_q == PH_IDLE) && start_i;
    ctrl_o.phase   = state_q;
    ctrl_o.step    = step_q;
    ctrl_o.cost_en = (step_q > STEP_W'(SKIP_STEPS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[sim/tb_top.sv]
// tb_top: self-checking testbench for the pid step-response itae cost evaluator
// holds a fixed-point predictor of the 200-step closed-loop run and checks every result
// depends on pme_pkg and pid_motor_itae_eval
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_STEPS = 200;
  localparam int unsigned N_SKIP  = 20;

  localparam longint DT_Q32    = 64'sd42949673;
  localparam longint KEEP_Q32  = 64'sd4252017623;
  localparam longint DRIVE_Q32 = 64'sd429496730;
  localparam longint ITAE_Q32  = 64'sd429497;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam longint COST_MAX  = 64'sd281474976710655;

  localparam logic [pme_pkg::GAIN_W-1:0] GAIN_ONES = '1;
  localparam logic signed [pme_pkg::DATA_W-1:0] SP_ONE  = 32'sh0001_0000;
  localparam logic signed [pme_pkg::DATA_W-1:0] SP_MAX  = 32'sh7fff_ffff;
  localparam logic signed [pme_pkg::DATA_W-1:0] SP_MIN  = 32'sh8000_0000;
  localparam logic signed [pme_pkg::DATA_W-1:0] SP_NEG1 = 32'shffff_0000;

  typedef struct packed {
    logic [pme_pkg::COST_W-1:0] cost;
    logic                       sat;
  } itae_res_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic                               busy_o;
  logic [pme_pkg::GAIN_W-1:0]         prop_gain_i = '0;
  logic [pme_pkg::GAIN_W-1:0]         integ_gain_i = '0;
  logic [pme_pkg::GAIN_W-1:0]         deriv_gain_i = '0;
  logic                               target_speed_we_i = 1'b0;
  logic signed [pme_pkg::DATA_W-1:0]  target_speed_i = '0;
  logic                               done_o;
  logic [pme_pkg::COST_W-1:0]         itae_cost_o;
  logic                               cost_saturated_o;

  itae_res_t   itae_q[$];
  longint      setpoint_q = 0;
  bit          gaps_on = 1'b1;
  int unsigned mismatch_cnt = 0;

  pid_motor_itae_eval #(
    .SIM_STEPS (N_STEPS),
    .SKIP_STEPS(N_SKIP)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .prop_gain_i      (prop_gain_i),
    .integ_gain_i     (integ_gain_i),
    .deriv_gain_i     (deriv_gain_i),
    .target_speed_we_i(target_speed_we_i),
    .target_speed_i   (target_speed_i),
    .done_o           (done_o),
    .itae_cost_o      (itae_cost_o),
    .cost_saturated_o (cost_saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(70_000_000);
    $display("FAIL");
    $finish;
  end

  // floor((x + 2^(n-1)) / 2^n)
  function automatic longint round_shift(input longint x, input int unsigned n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(input longint x, inout bit ovf);
    if (x > S32_MAX) begin
      ovf = 1'b1;
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      ovf = 1'b1;
      return S32_MIN;
    end
    return x;
  endfunction

  // full closed-loop step response for one set of gains
  function automatic itae_res_t itae_of_gains(input logic [pme_pkg::GAIN_W-1:0] kp_b,
                                              input logic [pme_pkg::GAIN_W-1:0] ki_b,
                                              input logic [pme_pkg::GAIN_W-1:0] kd_b,
                                              input longint setpoint);
    longint    kp, ki, kd, speed, integ, prev, err, deriv, u, mag, inc, acc;
    bit        ovf;
    itae_res_t r;
    kp = {40'd0, kp_b};
    ki = {40'd0, ki_b};
    kd = {40'd0, kd_b};
    speed = 0;
    integ = 0;
    prev = 0;
    acc = 0;
    ovf = 1'b0;
    for (int n = 0; n < N_STEPS; n++) begin
      err   = clamp32(setpoint - speed, ovf);
      integ = clamp32(integ + round_shift(err * DT_Q32, 32), ovf);
      deriv = clamp32((err - prev) * 100, ovf);
      u     = clamp32(round_shift(kp * err + ki * integ + kd * deriv, 16), ovf);
      speed = clamp32(round_shift(speed * KEEP_Q32, 32) + round_shift(u * DRIVE_Q32, 32), ovf);
      if (n > N_SKIP) begin
        mag = (err < 0) ? -err : err;
        inc = round_shift(longint'(n) * mag * ITAE_Q32, 32);
        if (inc > COST_MAX - acc) begin
          acc = COST_MAX;
          ovf = 1'b1;
        end else begin
          acc = acc + inc;
        end
      end
      prev = err;
    end
    r.cost = ovf ? COST_MAX[pme_pkg::COST_W-1:0] : acc[pme_pkg::COST_W-1:0];
    r.sat  = ovf;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    itae_res_t exp_r;
    if (rst_ni && done_o) begin
      if (itae_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: cost %h sat %b", itae_cost_o, cost_saturated_o);
      end else begin
        exp_r = itae_q.pop_front();
        if (itae_cost_o !== exp_r.cost || cost_saturated_o !== exp_r.sat) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: cost exp %h got %h, sat exp %b got %b",
                     exp_r.cost, itae_cost_o, exp_r.sat, cost_saturated_o);
        end
      end
    end
  end

  task automatic send_gains(input logic [pme_pkg::GAIN_W-1:0] kp,
                            input logic [pme_pkg::GAIN_W-1:0] ki,
                            input logic [pme_pkg::GAIN_W-1:0] kd);
    start_i      <= 1'b1;
    prop_gain_i  <= kp;
    integ_gain_i <= ki;
    deriv_gain_i <= kd;
    do @(posedge clk_i); while (busy_o);
    itae_q.push_back(itae_of_gains(kp, ki, kd, setpoint_q));
    if (gaps_on && $urandom_range(2, 0) == 0) begin
      start_i <= 1'b0;
      // sometimes let the request finish so the gap falls in the idle window
      if ($urandom_range(1, 0) == 1)
        do @(posedge clk_i); while (busy_o);
      repeat ($urandom_range(13, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_setpoint(input logic signed [pme_pkg::DATA_W-1:0] v);
    start_i <= 1'b0;
    while (itae_q.size() != 0 || busy_o) @(posedge clk_i);
    target_speed_we_i <= 1'b1;
    target_speed_i    <= v;
    @(posedge clk_i);
    target_speed_we_i <= 1'b0;
    setpoint_q = longint'(v);
  endtask

  function automatic logic [pme_pkg::GAIN_W-1:0] pick_gain();
    int unsigned w;
    logic [pme_pkg::GAIN_W:0] mask;
    w = ($urandom_range(4, 0) == 0) ? pme_pkg::GAIN_W : $urandom_range(20, 8);
    mask = (25'd1 << w) - 25'd1;
    return pme_pkg::GAIN_W'($urandom) & mask[pme_pkg::GAIN_W-1:0];
  endfunction

  function automatic logic signed [pme_pkg::DATA_W-1:0] pick_setpoint();
    logic signed [pme_pkg::DATA_W-1:0] v;
    int unsigned w;
    w = $urandom_range(32, 1);
    v = pme_pkg::DATA_W'($urandom & ((33'd1 << w) - 33'd1));
    if ($urandom_range(1, 0) == 1)
      v = -v;
    return v;
  endfunction

  task automatic test_reset_setpoint();
    send_gains('0, '0, '0);
    send_gains(GAIN_ONES, GAIN_ONES, GAIN_ONES);
  endtask

  task automatic test_unit_setpoint();
    write_setpoint(SP_ONE);
    send_gains('0, '0, '0);
    send_gains(24'h01_0000, 24'h00_4000, 24'h00_0100);
    send_gains(GAIN_ONES, '0, '0);
    send_gains('0, GAIN_ONES, '0);
    send_gains('0, '0, GAIN_ONES);
    send_gains(24'h55_5555, 24'haa_aaaa, 24'h55_5555);
  endtask

  task automatic test_setpoint_extremes();
    write_setpoint(SP_MAX);
    send_gains('0, '0, '0);
    send_gains(24'h01_0000, 24'h00_1000, 24'h00_0100);
    send_gains(GAIN_ONES, GAIN_ONES, GAIN_ONES);
    write_setpoint(SP_MIN);
    send_gains('0, '0, '0);
    send_gains(24'h01_0000, 24'h00_1000, 24'h00_0100);
    send_gains(GAIN_ONES, GAIN_ONES, GAIN_ONES);
  endtask

  task automatic test_negative_setpoint();
    write_setpoint(SP_NEG1);
    send_gains(24'h02_0000, 24'h00_8000, 24'h00_0040);
    send_gains(24'haa_aaaa, 24'h55_5555, 24'haa_aaaa);
  endtask

  task automatic test_random_tuning(input int unsigned n_req,
                                    input logic signed [pme_pkg::DATA_W-1:0] sp);
    write_setpoint(sp);
    repeat (n_req) send_gains(pick_gain(), pick_gain(), pick_gain());
  endtask

  task automatic test_back_to_back(input int unsigned n_req);
    gaps_on = 1'b0;
    test_random_tuning(n_req, pick_setpoint());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_setpoint();
    test_unit_setpoint();
    test_setpoint_extremes();
    test_negative_setpoint();
    test_random_tuning(100, SP_ONE);
    test_random_tuning(100, pick_setpoint());
    test_random_tuning(100, pick_setpoint());
    test_random_tuning(100, pick_setpoint());
    test_random_tuning(100, pick_setpoint());
    test_back_to_back(100);
    start_i <= 1'b0;
    while (itae_q.size() != 0) @(posedge clk_i);
    repeat (2300) @(posedge clk_i);
    if (mismatch_cnt == 0 && itae_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/core/pme_pkg.sv
rtl/core/pme_mul.sv
rtl/core/pme_datapath.sv
rtl/core/pme_ctrl.sv
rtl/core/pid_motor_itae_eval.sv
sim/tb_top.sv
